// File: rtl/terminal_key_sequence_decoder_macros.svh
// Assertion macros used by the terminal key sequence decoder top level.
`ifndef TERMINAL_KEY_SEQUENCE_DECODER_MACROS_SVH
`define TERMINAL_KEY_SEQUENCE_DECODER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TKSD_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tksd: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TKSD_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tksd: next-cycle check failed");

`endif

// File: rtl/tksd_pkg.sv
// Shared types and constants for the terminal key sequence decoder.
package tksd_pkg;

    localparam int CSI_MAX_PARAMS = 4;
    localparam int CSI_CNT_W      = $clog2(CSI_MAX_PARAMS + 1);
    localparam int CSI_IDX_W      = $clog2(CSI_MAX_PARAMS);

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int EV_W   = 28;
    localparam int MODE_W = 3;

    localparam logic [MODE_W-1:0] MODE_IDLE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ESC  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CSI  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SS3  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_UTF8 = 3'd4;

    localparam logic [EV_W-1:0] META_FLAG  = 28'h800_0000;
    localparam logic [EV_W-1:0] CTRL_FLAG  = 28'h400_0000;
    localparam logic [EV_W-1:0] SHIFT_FLAG = 28'h200_0000;

    localparam logic [CP_W-1:0] SK_BASE  = 21'h00E000;
    localparam logic [CP_W-1:0] SK_UP    = SK_BASE + 21'd0;
    localparam logic [CP_W-1:0] SK_DOWN  = SK_BASE + 21'd1;
    localparam logic [CP_W-1:0] SK_RIGHT = SK_BASE + 21'd2;
    localparam logic [CP_W-1:0] SK_LEFT  = SK_BASE + 21'd3;
    localparam logic [CP_W-1:0] SK_HOME  = SK_BASE + 21'd4;
    localparam logic [CP_W-1:0] SK_END   = SK_BASE + 21'd5;
    localparam logic [CP_W-1:0] SK_PGUP  = SK_BASE + 21'd6;
    localparam logic [CP_W-1:0] SK_PGDN  = SK_BASE + 21'd7;
    localparam logic [CP_W-1:0] SK_INS   = SK_BASE + 21'd8;
    localparam logic [CP_W-1:0] SK_DEL   = SK_BASE + 21'd9;
    localparam logic [CP_W-1:0] SK_F1    = SK_BASE + 21'd11;

    localparam logic [BYTE_W-1:0] ESC_CHAR  = 8'h1B;
    localparam logic [CP_W-1:0]   PARAM_MAX = 21'h1FFFFF;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Up to two key events produced by one item, in delivery order.
    typedef struct packed {
        logic            v0;
        logic [EV_W-1:0] ev0;
        logic            v1;
        logic [EV_W-1:0] ev1;
    } t_result;

    typedef struct packed {
        logic [FIFO_CNT_W-1:0] count;
        logic                  room;
    } t_fifo_stat;

endpackage

// File: rtl/terminal_key_sequence_decoder.sv
// Top level of the terminal key sequence decoder.
//
// The slave stream carries one item per terminal byte: tdata holds the byte and
// tuser is the timeout flag, which marks that the escape wait has expired (the
// byte is then ignored). The master stream carries key events: a codepoint or a
// special key from 0xE000 with shift, ctrl and meta in bits 25, 26 and 27.
// One item gives zero, one or two events; tlast marks the last event of an item.
// An item is held in an input register, decoded in one pass by short logic that
// updates the escape, CSI, SS3 and UTF-8 state, and its events go into a
// four-entry result queue. The first event is offered once the item has passed
// the input register and its events have been written into the queue. A new item
// is accepted in every cycle while the queue has room for two events, so the
// sustained rate is one item per cycle whenever the receiver takes one event per
// cycle; items that give two events are limited by the single-event output port.
// When the receiver stalls, the queue fills and tready drops; nothing is lost.
// Reset is synchronous and active low: it returns the decoder to idle with no
// pending escape and empties the queue. The CSI parameter store is not cleared;
// only entries written in the current sequence are ever read.
`include "terminal_key_sequence_decoder_macros.svh"

module terminal_key_sequence_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] timeout
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [27:0] key_event, [31:28] zero
    output logic        m_axis_tlast
);
    import tksd_pkg::*;

    logic                  r_in_valid;
    logic [BYTE_W-1:0]     r_in_byte;
    logic                  r_in_timeout;
    logic                  w_fire;
    logic                  w_in_take;
    t_result               w_res;
    t_fifo_stat            w_stat;
    logic [EV_W-1:0]       w_event;
    logic [FIFO_CNT_W-1:0] w_cnt_exp;

    // The held item is decoded once the queue can absorb its worst case.
    assign w_fire        = r_in_valid && w_stat.room;
    assign s_axis_tready = !r_in_valid || w_fire;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte    <= s_axis_tdata;
            r_in_timeout <= s_axis_tuser;
        end
    end

    tksd_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_fire),
        .i_byte    (r_in_byte),
        .i_timeout (r_in_timeout),
        .o_res     (w_res)
    );

    tksd_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_res    (w_res),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_event  (w_event),
        .o_last   (m_axis_tlast),
        .o_stat   (w_stat)
    );

    assign m_axis_tdata = {4'b0, w_event};

    // Queue occupancy expected after this cycle's pushes and pop.
    assign w_cnt_exp = w_stat.count + FIFO_CNT_W'(w_res.v0) + FIFO_CNT_W'(w_res.v1)
                     - FIFO_CNT_W'(m_axis_tvalid && m_axis_tready);

    `TKSD_ASSERT_IMP(a_res_only_on_fire, w_res.v0 || w_res.v1, w_fire)
    `TKSD_ASSERT_IMP(a_timeout_single, w_fire && r_in_timeout, !(w_res.v0 && w_res.v1))
    `TKSD_ASSERT_IMP(a_valid_matches_count, 1'b1, m_axis_tvalid == (w_stat.count != '0))
    `TKSD_ASSERT_NXT(a_count_tracks, i_rst_n, w_stat.count == $past(w_cnt_exp))

endmodule

// File: rtl/tksd_core.sv
// Decode state and single-pass key sequence decode logic.
module tksd_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  logic [tksd_pkg::BYTE_W-1:0]  i_byte,
    input  logic                         i_timeout,
    output tksd_pkg::t_result            o_res
);
    import tksd_pkg::*;

    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_LBRK  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_O     = 8'h4F;
    localparam logic [BYTE_W-1:0] CH_A     = 8'h41;
    localparam logic [BYTE_W-1:0] CH_B     = 8'h42;
    localparam logic [BYTE_W-1:0] CH_C     = 8'h43;
    localparam logic [BYTE_W-1:0] CH_D     = 8'h44;
    localparam logic [BYTE_W-1:0] CH_F     = 8'h46;
    localparam logic [BYTE_W-1:0] CH_H     = 8'h48;
    localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
    localparam logic [BYTE_W-1:0] CH_Q     = 8'h51;
    localparam logic [BYTE_W-1:0] CH_R     = 8'h52;
    localparam logic [BYTE_W-1:0] CH_S     = 8'h53;
    localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;

    typedef struct packed {
        logic              push;
        logic [EV_W-1:0]   ev;
        logic [MODE_W-1:0] mode;
        logic              meta;
        logic              load;
        logic [CP_W-1:0]   cp;
        logic [1:0]        left;
    } t_begin;

    // A byte that starts a new event, with the given pending meta flag.
    function automatic t_begin begin_byte(input logic [BYTE_W-1:0] b, input logic m);
        t_begin r;
        logic [EV_W-1:0] ev;
        r      = '0;
        r.mode = MODE_IDLE;
        ev     = '0;
        if (b == ESC_CHAR) begin
            r.mode = MODE_ESC;
            r.meta = m;
        end else if (b < 8'h20) begin
            if (b == 8'h09 || b == 8'h0D) ev = {20'b0, b};
            else if (b == 8'h0A)          ev = CTRL_FLAG | 28'h6A;
            else if (b == 8'h00)          ev = CTRL_FLAG | 28'h20;
            else if (b <= 8'h1A)          ev = CTRL_FLAG | {20'b0, b + 8'h60};
            else                          ev = CTRL_FLAG | {20'b0, b + 8'h40};
            r.push = 1'b1;
            r.ev   = ev | (m ? META_FLAG : '0);
        end else if (b <= 8'h7F) begin
            r.push = 1'b1;
            r.ev   = {20'b0, b} | (m ? META_FLAG : '0);
        end else if (b < 8'hC0) begin
            // Stray continuation byte: only a pending escape survives.
            r.push = m;
            r.ev   = {20'b0, ESC_CHAR};
        end else begin
            r.mode = MODE_UTF8;
            r.meta = m;
            r.load = 1'b1;
            if (b[7:5] == 3'b110) begin
                r.cp   = {16'b0, b[4:0]};
                r.left = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                r.cp   = {17'b0, b[3:0]};
                r.left = 2'd2;
            end else begin
                r.cp   = {18'b0, b[2:0]};
                r.left = 2'd3;
            end
        end
        return r;
    endfunction

    // Closing a sequence: a zero value is swallowed unless an escape is pending.
    function automatic logic [EV_W:0] finish_ev(input logic [EV_W-1:0] ev, input logic m);
        logic [EV_W:0] r;
        if (ev != '0) r = {1'b1, ev | (m ? META_FLAG : '0)};
        else          r = {m, {20'b0, ESC_CHAR}};
        return r;
    endfunction

    function automatic logic [EV_W-1:0] csi_decode(
        input logic [BYTE_W-1:0]    fin,
        input logic [CP_W-1:0]      p0_in,
        input logic [CP_W-1:0]      p1,
        input logic [CP_W-1:0]      p2,
        input logic [CSI_CNT_W-1:0] cnt
    );
        logic [CP_W-1:0] p0;
        logic [CP_W-1:0] m;
        logic [EV_W-1:0] mods;
        logic [CP_W-1:0] base;
        logic            hit;
        logic [EV_W-1:0] r;
        p0   = (cnt >= CSI_CNT_W'(1)) ? p0_in : '0;
        m    = (p1 != '0) ? p1 - 21'd1 : '0;
        mods = '0;
        if (cnt >= CSI_CNT_W'(2))
            mods = (m[0] ? SHIFT_FLAG : '0) | (m[1] ? META_FLAG : '0)
                 | (m[2] ? CTRL_FLAG : '0);
        base = '0;
        hit  = 1'b1;
        r    = '0;
        unique case (fin)
            CH_A: base = SK_UP;
            CH_B: base = SK_DOWN;
            CH_C: base = SK_RIGHT;
            CH_D: base = SK_LEFT;
            CH_H: base = SK_HOME;
            CH_F: base = SK_END;
            CH_TILDE: begin
                if (p0 == 21'd1)                       base = SK_HOME;
                else if (p0 == 21'd2)                  base = SK_INS;
                else if (p0 == 21'd3)                  base = SK_DEL;
                else if (p0 == 21'd4)                  base = SK_END;
                else if (p0 == 21'd5)                  base = SK_PGUP;
                else if (p0 == 21'd6)                  base = SK_PGDN;
                else if (p0 >= 21'd11 && p0 <= 21'd15) base = SK_F1 + p0 - 21'd11;
                else if (p0 >= 21'd17 && p0 <= 21'd21) base = SK_F1 + p0 - 21'd12;
                else if (p0 >= 21'd23 && p0 <= 21'd24) base = SK_F1 + p0 - 21'd13;
                else begin
                    hit = 1'b0;
                    // modifyOtherKeys: the third parameter is the codepoint.
                    if (p0 == 21'd27 && cnt >= CSI_CNT_W'(3)) r = mods | {7'b0, p2};
                end
            end
            default: hit = 1'b0;
        endcase
        if (hit) r = mods | {7'b0, base};
        return r;
    endfunction

    logic [MODE_W-1:0]    r_mode, n_mode;
    logic                 r_meta, n_meta;
    logic [1:0]           r_left, n_left;
    logic [CP_W-1:0]      r_cp, n_cp;
    logic [CP_W-1:0]      r_param [CSI_MAX_PARAMS];
    logic [CSI_CNT_W-1:0] r_pcnt, n_pcnt;
    logic [CP_W-1:0]      r_acc, n_acc;
    logic                 r_seen, n_seen;

    logic                 w_pwr_en;
    logic [CP_W-1:0]      w_pval;
    logic                 w_store_ok;
    logic [CP_W-1:0]      w_peff [3];
    logic [CSI_CNT_W-1:0] w_cnt_eff;
    logic [24:0]          w_digit_sum;
    logic [CP_W-1:0]      w_cp_new;
    logic [1:0]           w_left_new;
    logic [EV_W-1:0]      w_ss3;
    logic                 w_push_a, w_push_b;
    logic [EV_W-1:0]      w_ev_a, w_ev_b;
    t_begin               w_bg;

    always_comb begin
        w_pval     = r_seen ? r_acc : '0;
        w_store_ok = (r_pcnt < CSI_CNT_W'(CSI_MAX_PARAMS));
        w_cnt_eff  = w_store_ok ? r_pcnt + CSI_CNT_W'(1) : r_pcnt;
        for (int i = 0; i < 3; i++) begin
            w_peff[i] = (w_store_ok && r_pcnt == CSI_CNT_W'(i)) ? w_pval : r_param[i];
        end
        w_digit_sum = {1'b0, r_acc, 3'b0} + {3'b0, r_acc, 1'b0} + {21'b0, i_byte[3:0]};
        w_cp_new    = {r_cp[CP_W-7:0], i_byte[5:0]};
        w_left_new  = (r_left != 2'd0) ? r_left - 2'd1 : 2'd0;

        case (i_byte)
            CH_A: w_ss3 = {7'b0, SK_UP};
            CH_B: w_ss3 = {7'b0, SK_DOWN};
            CH_C: w_ss3 = {7'b0, SK_RIGHT};
            CH_D: w_ss3 = {7'b0, SK_LEFT};
            CH_H: w_ss3 = {7'b0, SK_HOME};
            CH_F: w_ss3 = {7'b0, SK_END};
            CH_P, CH_Q, CH_R, CH_S: w_ss3 = {7'b0, SK_F1 + {19'b0, i_byte[1:0]}};
            default: w_ss3 = '0;
        endcase
    end

    always_comb begin
        n_mode   = r_mode;
        n_meta   = r_meta;
        n_left   = r_left;
        n_cp     = r_cp;
        n_pcnt   = r_pcnt;
        n_acc    = r_acc;
        n_seen   = r_seen;
        w_pwr_en = 1'b0;
        w_push_a = 1'b0;
        w_push_b = 1'b0;
        w_ev_a   = '0;
        w_ev_b   = '0;
        w_bg     = begin_byte(i_byte, r_meta);

        if (i_timeout) begin
            if (r_mode == MODE_ESC) begin
                {w_push_a, w_ev_a} = finish_ev({20'b0, ESC_CHAR}, r_meta);
                n_meta = 1'b0;
                n_mode = MODE_IDLE;
            end
        end else begin
            unique case (r_mode)
                MODE_ESC: begin
                    if (i_byte == ESC_CHAR) begin
                        n_meta = 1'b1;
                    end else if (i_byte == CH_LBRK) begin
                        n_mode = MODE_CSI;
                        n_pcnt = '0;
                        n_acc  = '0;
                        n_seen = 1'b0;
                    end else if (i_byte == CH_O) begin
                        n_mode = MODE_SS3;
                    end else begin
                        w_bg     = begin_byte(i_byte, 1'b1);
                        w_push_a = w_bg.push;
                        w_ev_a   = w_bg.ev;
                        n_mode   = w_bg.mode;
                        n_meta   = w_bg.meta;
                        if (w_bg.load) begin
                            n_cp   = w_bg.cp;
                            n_left = w_bg.left;
                        end
                    end
                end
                MODE_CSI: begin
                    if (i_byte >= CH_ZERO && i_byte <= CH_NINE) begin
                        n_acc  = (w_digit_sum > {4'b0, PARAM_MAX}) ? PARAM_MAX
                                                                   : w_digit_sum[CP_W-1:0];
                        n_seen = 1'b1;
                    end else begin
                        w_pwr_en = w_store_ok;
                        n_pcnt   = w_cnt_eff;
                        n_acc    = '0;
                        n_seen   = 1'b0;
                        if (i_byte != CH_SEMI) begin
                            {w_push_a, w_ev_a} = finish_ev(
                                csi_decode(i_byte, w_peff[0], w_peff[1], w_peff[2], w_cnt_eff),
                                r_meta);
                            n_meta = 1'b0;
                            n_mode = MODE_IDLE;
                        end
                    end
                end
                MODE_SS3: begin
                    {w_push_a, w_ev_a} = finish_ev(w_ss3, r_meta);
                    n_meta = 1'b0;
                    n_mode = MODE_IDLE;
                end
                MODE_UTF8: begin
                    if (i_byte[7:6] == 2'b10) begin
                        n_cp   = w_cp_new;
                        n_left = w_left_new;
                        if (w_left_new == 2'd0) begin
                            {w_push_a, w_ev_a} = finish_ev({7'b0, w_cp_new}, r_meta);
                            n_meta = 1'b0;
                            n_mode = MODE_IDLE;
                        end
                    end else begin
                        // Broken sequence: drop the partial, then take the byte afresh.
                        n_left   = 2'd0;
                        w_push_a = r_meta;
                        w_ev_a   = {20'b0, ESC_CHAR};
                        w_bg     = begin_byte(i_byte, 1'b0);
                        w_push_b = w_bg.push;
                        w_ev_b   = w_bg.ev;
                        n_mode   = w_bg.mode;
                        n_meta   = w_bg.meta;
                        if (w_bg.load) begin
                            n_cp   = w_bg.cp;
                            n_left = w_bg.left;
                        end
                    end
                end
                default: begin
                    w_push_a = w_bg.push;
                    w_ev_a   = w_bg.ev;
                    n_mode   = w_bg.mode;
                    n_meta   = w_bg.meta;
                    if (w_bg.load) begin
                        n_cp   = w_bg.cp;
                        n_left = w_bg.left;
                    end
                end
            endcase
        end
    end

    assign o_res.v0  = i_fire && w_push_a;
    assign o_res.ev0 = w_ev_a;
    assign o_res.v1  = i_fire && w_push_b;
    assign o_res.ev1 = w_ev_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_meta <= 1'b0;
            r_left <= 2'd0;
            r_cp   <= '0;
            r_pcnt <= '0;
            r_acc  <= '0;
            r_seen <= 1'b0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_meta <= n_meta;
            r_left <= n_left;
            r_cp   <= n_cp;
            r_pcnt <= n_pcnt;
            r_acc  <= n_acc;
            r_seen <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && w_pwr_en) begin
            r_param[r_pcnt[CSI_IDX_W-1:0]] <= w_pval;
        end
    end

endmodule

// File: rtl/tksd_fifo.sv
// Result queue that takes up to two key events per cycle and delivers one whenever the receiver is ready.
module tksd_fifo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tksd_pkg::t_result           i_res,
    output logic                        o_tvalid,
    input  logic                        i_tready,
    output logic [tksd_pkg::EV_W-1:0]   o_event,
    output logic                        o_last,
    output tksd_pkg::t_fifo_stat        o_stat
);
    import tksd_pkg::*;

    logic [EV_W-1:0]       r_ev   [FIFO_DEPTH];
    logic                  r_last [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr, n_wr;
    logic [FIFO_PTR_W-1:0] r_rd, n_rd;
    logic [FIFO_CNT_W-1:0] r_count, n_count;
    logic [FIFO_PTR_W-1:0] w_wr1;
    logic                  w_pop;

    assign w_pop = (r_count != '0) && i_tready;
    assign w_wr1 = r_wr + FIFO_PTR_W'(i_res.v0);

    always_comb begin
        n_wr    = r_wr + FIFO_PTR_W'(i_res.v0) + FIFO_PTR_W'(i_res.v1);
        n_rd    = r_rd + FIFO_PTR_W'(w_pop);
        n_count = r_count + FIFO_CNT_W'(i_res.v0) + FIFO_CNT_W'(i_res.v1)
                - FIFO_CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res.v0) begin
            r_ev[r_wr]   <= i_res.ev0;
            r_last[r_wr] <= !i_res.v1;
        end
        if (i_res.v1) begin
            r_ev[w_wr1]   <= i_res.ev1;
            r_last[w_wr1] <= 1'b1;
        end
    end

    assign o_tvalid     = (r_count != '0);
    assign o_event      = r_ev[r_rd];
    assign o_last       = r_last[r_rd];
    assign o_stat.count = r_count;
    assign o_stat.room  = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));

endmodule

// File: test/terminal_key_sequence_decoder_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the terminal key sequence decoder stream block.
module terminal_key_sequence_decoder_test;
    import tksd_pkg::*;

    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int HOLDOFF_CYCLES   = 200;
    localparam int DRAIN_CYCLES     = 16;
    localparam int SHOWN_MISMATCHES = 10;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SUB   = 8'h1A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_CONT  = 8'h80;
    localparam logic [7:0] CH_LEAD  = 8'hC0;

    // Ctrl letters map 0x01-0x1A onto 'a'-'z', and 0x1C-0x1F onto '\'-'_'.
    localparam logic [7:0] CTRL_LETTER_OFS = 8'h60;
    localparam logic [7:0] CTRL_SYMBOL_OFS = 8'h40;
    localparam logic [EV_W-1:0] KEY_CTRL_J     = CTRL_FLAG | 28'h6A;
    localparam logic [EV_W-1:0] KEY_CTRL_SPACE = CTRL_FLAG | 28'h20;

    // First CSI parameter codes that select a key before a '~' final.
    localparam int TK_HOME  = 1;
    localparam int TK_INS   = 2;
    localparam int TK_DEL   = 3;
    localparam int TK_END   = 4;
    localparam int TK_PGUP  = 5;
    localparam int TK_PGDN  = 6;
    localparam int TK_F1    = 11;
    localparam int TK_F5    = 15;
    localparam int TK_F6    = 17;
    localparam int TK_F10   = 21;
    localparam int TK_F11   = 23;
    localparam int TK_F12   = 24;
    localparam int TK_OTHER = 27;

    localparam logic [8:0] TIMEOUT_ITEM = 9'h100;

    typedef struct {
        logic [EV_W-1:0] key;
        bit              last;
    } t_key_event;

    typedef enum int {PH_NONE, PH_SENDER, PH_RECEIVER, PH_BOTH} t_idle_mode;

    // Decodes accepted items on its own and checks each delivered key event.
    class key_event_scoreboard;
        logic [MODE_W-1:0] mode;
        bit                meta;
        int unsigned       utf8_left;
        logic [CP_W-1:0]   cp_acc;
        logic [CP_W-1:0]   params [CSI_MAX_PARAMS];
        int unsigned       n_params;
        logic [CP_W-1:0]   digits;
        bit                digits_seen;
        logic [EV_W-1:0]   item_keys [$];
        t_key_event        expected_keys [$];
        int unsigned       n_bad;

        function new();
            mode        = MODE_IDLE;
            meta        = 1'b0;
            utf8_left   = 0;
            cp_acc      = '0;
            n_params    = 0;
            digits      = '0;
            digits_seen = 1'b0;
            n_bad       = 0;
            foreach (params[i]) params[i] = '0;
        endfunction

        function int unsigned outstanding();
            return expected_keys.size();
        endfunction

        function void emit(logic [EV_W-1:0] key);
            if (item_keys.size() < 2) item_keys.push_back(key);
        endfunction

        // Ends the open sequence; a zero key is swallowed, leaving only a pending ESC.
        function void complete(logic [EV_W-1:0] key);
            if (key != '0) emit(key | (meta ? META_FLAG : '0));
            else if (meta) emit(EV_W'(ESC_CHAR));
            meta = 1'b0;
            mode = MODE_IDLE;
        endfunction

        function void keep_param();
            if (n_params < CSI_MAX_PARAMS) begin
                params[n_params] = digits_seen ? digits : '0;
                n_params++;
            end
            digits      = '0;
            digits_seen = 1'b0;
        endfunction

        function void start_key(logic [7:0] b);
            if (b == ESC_CHAR) begin
                mode = MODE_ESC;
            end else if (b < CH_SPACE) begin
                if (b == CH_TAB || b == CH_CR) complete(EV_W'(b));
                else if (b == CH_LF) complete(KEY_CTRL_J);
                else if (b == CH_NUL) complete(KEY_CTRL_SPACE);
                else if (b <= CH_SUB) complete(CTRL_FLAG | (b + CTRL_LETTER_OFS));
                else complete(CTRL_FLAG | (b + CTRL_SYMBOL_OFS));
            end else if (b <= CH_DEL) begin
                complete(EV_W'(b));
            end else if (b < CH_LEAD) begin
                complete('0);
            end else begin
                // Leads from 0xF8 up count as four-byte leads with three payload bits.
                if (b[7:5] == 3'b110) begin
                    cp_acc    = CP_W'(b[4:0]);
                    utf8_left = 1;
                end else if (b[7:4] == 4'b1110) begin
                    cp_acc    = CP_W'(b[3:0]);
                    utf8_left = 2;
                end else begin
                    cp_acc    = CP_W'(b[2:0]);
                    utf8_left = 3;
                end
                mode = MODE_UTF8;
            end
        endfunction

        function void note_item(logic [7:0] b, logic timeout);
            logic [31:0]     wide;
            logic [CP_W-1:0] p0;
            logic [CP_W-1:0] m;
            logic [EV_W-1:0] mods;
            logic [EV_W-1:0] key;
            item_keys.delete();
            if (timeout) begin
                // Only an open escape reacts to the expired wait.
                if (mode == MODE_ESC) complete(EV_W'(ESC_CHAR));
            end else begin
                case (mode)
                    MODE_ESC: begin
                        if (b == ESC_CHAR) begin
                            meta = 1'b1;
                        end else if (b == "[") begin
                            mode        = MODE_CSI;
                            n_params    = 0;
                            digits      = '0;
                            digits_seen = 1'b0;
                        end else if (b == "O") begin
                            mode = MODE_SS3;
                        end else begin
                            meta = 1'b1;
                            mode = MODE_IDLE;
                            start_key(b);
                        end
                    end
                    MODE_CSI: begin
                        if (b >= "0" && b <= "9") begin
                            wide        = digits * 10 + (b - "0");
                            digits      = (wide > PARAM_MAX) ? PARAM_MAX : wide[CP_W-1:0];
                            digits_seen = 1'b1;
                        end else if (b == ";") begin
                            keep_param();
                        end else begin
                            keep_param();
                            p0   = (n_params >= 1) ? params[0] : '0;
                            mods = '0;
                            if (n_params >= 2) begin
                                m = (params[1] > 0) ? params[1] - 1 : '0;
                                if (m[0]) mods |= SHIFT_FLAG;
                                if (m[1]) mods |= META_FLAG;
                                if (m[2]) mods |= CTRL_FLAG;
                            end
                            key = '0;
                            case (b)
                                "A": key = mods | SK_UP;
                                "B": key = mods | SK_DOWN;
                                "C": key = mods | SK_RIGHT;
                                "D": key = mods | SK_LEFT;
                                "H": key = mods | SK_HOME;
                                "F": key = mods | SK_END;
                                "~": begin
                                    if (p0 == TK_HOME) key = mods | SK_HOME;
                                    else if (p0 == TK_INS) key = mods | SK_INS;
                                    else if (p0 == TK_DEL) key = mods | SK_DEL;
                                    else if (p0 == TK_END) key = mods | SK_END;
                                    else if (p0 == TK_PGUP) key = mods | SK_PGUP;
                                    else if (p0 == TK_PGDN) key = mods | SK_PGDN;
                                    else if (p0 >= TK_F1 && p0 <= TK_F5)
                                        key = mods | (SK_F1 + p0 - TK_F1);
                                    else if (p0 >= TK_F6 && p0 <= TK_F10)
                                        key = mods | (SK_F1 + p0 - TK_F6 + 5);
                                    else if (p0 >= TK_F11 && p0 <= TK_F12)
                                        key = mods | (SK_F1 + p0 - TK_F11 + 10);
                                    else if (p0 == TK_OTHER && n_params >= 3)
                                        key = mods | params[2];
                                end
                                default: key = '0;
                            endcase
                            complete(key);
                        end
                    end
                    MODE_SS3: begin
                        case (b)
                            "A": complete(EV_W'(SK_UP));
                            "B": complete(EV_W'(SK_DOWN));
                            "C": complete(EV_W'(SK_RIGHT));
                            "D": complete(EV_W'(SK_LEFT));
                            "H": complete(EV_W'(SK_HOME));
                            "F": complete(EV_W'(SK_END));
                            "P", "Q", "R", "S": complete(EV_W'(SK_F1 + (b - "P")));
                            default: complete('0);
                        endcase
                    end
                    MODE_UTF8: begin
                        if (b[7:6] == 2'b10) begin
                            cp_acc = {cp_acc[CP_W-7:0], b[5:0]};
                            if (utf8_left > 0) utf8_left--;
                            if (utf8_left == 0) complete(EV_W'(cp_acc));
                        end else begin
                            // A broken sequence is dropped and the byte starts afresh.
                            utf8_left = 0;
                            complete('0);
                            start_key(b);
                        end
                    end
                    default: begin
                        mode = MODE_IDLE;
                        start_key(b);
                    end
                endcase
            end
            foreach (item_keys[i])
                expected_keys.push_back('{key: item_keys[i], last: (i == item_keys.size() - 1)});
        endfunction

        function void check_event(logic [31:0] data, logic last);
            t_key_event want;
            if (expected_keys.size() == 0) begin
                n_bad++;
                if (n_bad <= SHOWN_MISMATCHES)
                    $display("%0t: unexpected key event %08h last %0b", $time, data, last);
                return;
            end
            want = expected_keys.pop_front();
            if (data !== 32'(want.key) || last !== want.last) begin
                n_bad++;
                if (n_bad <= SHOWN_MISMATCHES)
                    $display("%0t: key event mismatch: expected %08h last %0b, got %08h last %0b",
                             $time, 32'(want.key), want.last, data, last);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        s_axis_tuser;   // [0] timeout
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [27:0] key_event, [31:28] zero
    logic        m_axis_tlast;

    key_event_scoreboard sb;
    t_idle_mode          idle_phase = PH_NONE;
    int                  stall_left = 0;
    int                  quiet_cycles = 0;
    int unsigned         n_items = 0;

    int unsigned tilde_key_codes [] = '{TK_HOME, TK_INS, TK_DEL, TK_END, TK_PGUP, TK_PGDN,
        TK_F1, 12, 13, 14, TK_F5, TK_F6, 18, 19, 20, TK_F10, TK_F11, TK_F12, TK_OTHER};
    string csi_finals = "ABCDHF";
    string ss3_finals = "ABCDHFPQRS";

    // Short opening run: C0 extremes, DEL, stray continuation, idle timeout, ESC with a
    // broken UTF-8 sequence, repeated ESC, lone ESC, unknown CSI final, SS3 F1 and an
    // 0xFF lead byte.
    logic [8:0] opening_items [] = '{
        {1'b0, CH_NUL}, {1'b0, 8'h1F}, {1'b0, CH_DEL}, {1'b0, CH_CONT}, TIMEOUT_ITEM,
        {1'b0, ESC_CHAR}, {1'b0, 8'hE2}, {1'b0, "A"},
        {1'b0, ESC_CHAR}, {1'b0, ESC_CHAR}, TIMEOUT_ITEM,
        {1'b0, ESC_CHAR}, TIMEOUT_ITEM,
        {1'b0, ESC_CHAR}, {1'b0, "["}, {1'b0, "Z"},
        {1'b0, ESC_CHAR}, {1'b0, "O"}, {1'b0, "P"},
        {1'b0, 8'hFF}, {1'b0, 8'hBF}, {1'b0, 8'hBF}, {1'b0, 8'hBF}
    };

    terminal_key_sequence_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic bit roll(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Offers one item from a falling edge and returns at the falling edge after it is taken.
    task automatic push_item(logic [7:0] data, logic timeout);
        while (roll((idle_phase == PH_SENDER) ? 56 : (idle_phase == PH_BOTH) ? 6 : 0)) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= timeout;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(data, timeout);
        n_items++;
        @(negedge i_clk);
    endtask

    // A byte of a sequence, now and then preceded by a timeout mark.
    task automatic push_byte(logic [7:0] data);
        if ($urandom_range(0, 49) == 0) push_item(8'($urandom), 1'b1);
        push_item(data, 1'b0);
    endtask

    task automatic put_utf8();
        int unsigned len;
        int unsigned n_cont;
        len = $urandom_range(2, 4);
        case (len)
            2: push_byte(8'($urandom_range(8'hC0, 8'hDF)));
            3: push_byte(8'($urandom_range(8'hE0, 8'hEF)));
            default: push_byte(8'($urandom_range(8'hF0, 8'hFF)));
        endcase
        // One sequence in ten is cut short so the next key breaks it.
        n_cont = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 2) : len - 1;
        repeat (n_cont) push_byte(8'($urandom_range(8'h80, 8'hBF)));
    endtask

    task automatic send_random_key();
        int unsigned kind;
        int unsigned sel;
        int unsigned n;
        logic [31:0] val;
        logic [7:0]  fin;
        string       digits_txt;
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            push_byte(8'($urandom_range(8'h20, 8'h7E)));
        end else if (kind < 22) begin
            push_byte((kind < 20) ? 8'($urandom_range(0, 8'h1F)) : CH_DEL);
        end else if (kind < 34) begin
            put_utf8();
        end else if (kind < 38) begin
            push_byte(8'($urandom_range(8'h80, 8'hBF)));
        end else if (kind < 44) begin
            // Lone or doubled ESC closed by the wait expiring.
            push_item(ESC_CHAR, 1'b0);
            if (kind < 41) push_item(ESC_CHAR, 1'b0);
            push_item(8'($urandom), 1'b1);
        end else if (kind < 54) begin
            push_byte(ESC_CHAR);
            case ($urandom_range(0, 2))
                0: push_byte(8'($urandom_range(8'h20, 8'h7E)));
                1: push_byte(8'($urandom_range(0, 8'h1F)));
                default: put_utf8();
            endcase
        end else if (kind < 80) begin
            if ($urandom_range(0, 6) == 0) push_byte(ESC_CHAR);
            push_byte(ESC_CHAR);
            push_byte("[");
            sel = $urandom_range(0, 9);
            fin = (sel < 3) ? csi_finals[$urandom_range(0, 5)] : (sel < 8) ? "~" : 8'($urandom);
            n = (fin == "~") ? $urandom_range(1, 6) : $urandom_range(0, 6);
            for (int i = 0; i < n; i++) begin
                if (i > 0) push_byte(";");
                sel = $urandom_range(0, 19);
                // Selection zero leaves the parameter empty.
                if (sel != 0) begin
                    if (sel == 1) val = $urandom_range(32'hFFFF_FFFF, 32'd2_000_000);
                    else if (i == 0) val = (sel < 5) ? $urandom_range(0, 30)
                                                     : tilde_key_codes[$urandom_range(0, 18)];
                    else if (i == 1) val = $urandom_range(0, 9);
                    else if (i == 2) val = (sel < 12) ? $urandom_range(0, 8'h7F)
                                                      : $urandom_range(0, PARAM_MAX);
                    else val = $urandom_range(0, 99);
                    if (sel == 3) push_byte("0");
                    digits_txt = $sformatf("%0d", val);
                    foreach (digits_txt[k]) push_byte(digits_txt[k]);
                end
            end
            push_byte(fin);
            if ((fin >= "0" && fin <= "9") || fin == ";") push_byte("~");
        end else if (kind < 90) begin
            push_byte(ESC_CHAR);
            push_byte("O");
            push_byte(($urandom_range(0, 4) != 0) ? ss3_finals[$urandom_range(0, 9)]
                                                  : 8'($urandom));
        end else begin
            push_item(8'($urandom), $urandom_range(0, 3) == 0);
        end
    endtask

    // Receiver: a requested hold-off first, otherwise stalls by the current phase.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= !roll((idle_phase == PH_RECEIVER) ? 56 :
                                       (idle_phase == PH_BOTH) ? 6 : 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_event(m_axis_tdata, m_axis_tlast);
    end

    // Ends the run when neither side has moved an item for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("terminal_key_sequence_decoder verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        sb            = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening_items[i]) push_item(opening_items[i][7:0], opening_items[i][8]);

        // Back-to-back items against a long receiver hold-off fill the result queue.
        stall_left = HOLDOFF_CYCLES;
        while (n_items < 500) send_random_key();

        idle_phase = PH_SENDER;
        while (n_items < 750) send_random_key();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (sb.outstanding() != 0);
        while (n_items < 1000) send_random_key();

        idle_phase = PH_RECEIVER;
        while (n_items < 1500) send_random_key();

        idle_phase = PH_BOTH;
        while (n_items < 1950) send_random_key();

        s_axis_tvalid <= 1'b0;
        idle_phase = PH_NONE;
        do @(negedge i_clk); while (sb.outstanding() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (sb.n_bad == 0 && sb.outstanding() == 0) begin
            $display("terminal_key_sequence_decoder verification clean");
        end else begin
            $display("terminal_key_sequence_decoder verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/tksd_pkg.sv
rtl/tksd_core.sv
rtl/tksd_fifo.sv
rtl/terminal_key_sequence_decoder.sv
test/terminal_key_sequence_decoder_test.sv
